/* src/bls_pkg.sv */
// Package: widths, codes, command/status structs and item types for the box smoother.
package bls_pkg;

   localparam int unsigned COORD_W    = 16;
   localparam int unsigned SIZE_W     = 15;
   localparam int unsigned STAMP_W    = 32;
   localparam int unsigned TAU_W      = 16;
   localparam int unsigned CENTER_W   = 18;
   localparam int unsigned SIDE_W     = 16;
   localparam int unsigned SUB_SHIFT  = 4;
   localparam int unsigned GAP_T_W    = 8;
   localparam int unsigned T16_W      = GAP_T_W + SUB_SHIFT;
   localparam int unsigned DEN_W      = 17;
   localparam int unsigned MUL_A_W    = 17;
   localparam int unsigned PROD_W     = 35;
   localparam int unsigned QUO_W      = PROD_W - DEN_W;

   localparam logic [STAMP_W-1:0] GAP_LIMIT_MS     = 32'd200;
   localparam logic [TAU_W-1:0]   SCALE_TAU_RESET  = 16'd2548;
   localparam logic [TAU_W-1:0]   CENTER_TAU_RESET = 16'd510;

   typedef enum logic [0:0] {
      CSR_SCALE_TAU  = 1'b0,
      CSR_CENTER_TAU = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      CHAN_X,
      CHAN_Y,
      CHAN_SIDE
   } chan_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_FIRST,
      ST_MUL_A,
      ST_MUL_B,
      ST_SUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic     capture;
      logic     prep;
      logic     load_first;
      logic     mul_a;
      logic     mul_b;
      logic     sum;
      logic     div_start;
      logic     take_cur;
      logic     write_quo;
      logic     load_out;
      chan_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic primed;
      logic bypass;
      logic div_busy;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] box_left;
      logic signed [COORD_W-1:0] box_top;
      logic [SIZE_W-1:0]         box_width;
      logic [SIZE_W-1:0]         box_height;
      logic [STAMP_W-1:0]        stamp_ms;
   } req_item_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] smooth_left;
      logic signed [COORD_W-1:0] smooth_top;
      logic [SIZE_W-1:0]         smooth_width;
      logic [SIZE_W-1:0]         smooth_height;
   } rsp_item_type;

endpackage

/* src/bls_req_if.sv */
// Interface: input box channel with valid/ready handshake.
interface bls_req_if;
   logic                           valid;
   logic                           ready;
   logic signed [bls_pkg::COORD_W-1:0] box_left;
   logic signed [bls_pkg::COORD_W-1:0] box_top;
   logic [bls_pkg::SIZE_W-1:0]     box_width;
   logic [bls_pkg::SIZE_W-1:0]     box_height;
   logic [bls_pkg::STAMP_W-1:0]    stamp_ms;

   modport source (output valid, box_left, box_top, box_width, box_height, stamp_ms,
                   input ready);
   modport sink   (input valid, box_left, box_top, box_width, box_height, stamp_ms,
                   output ready);
endinterface

/* src/bls_rsp_if.sv */
// Interface: smoothed box result channel with valid/ready handshake.
interface bls_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [bls_pkg::COORD_W-1:0] smooth_left;
   logic signed [bls_pkg::COORD_W-1:0] smooth_top;
   logic [bls_pkg::SIZE_W-1:0]     smooth_width;
   logic [bls_pkg::SIZE_W-1:0]     smooth_height;

   modport source (output valid, smooth_left, smooth_top, smooth_width, smooth_height,
                   input ready);
   modport sink   (input valid, smooth_left, smooth_top, smooth_width, smooth_height,
                   output ready);
endinterface

/* src/bls_csr_if.sv */
// Interface: configuration register write channel.
interface bls_csr_if;
   logic                        valid;
   logic                        ready;
   bls_pkg::csr_index_type      index;
   logic [bls_pkg::TAU_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/bls_divider.sv */
// Shared signed-by-unsigned restoring divider, one quotient bit per cycle, truncating.
module bls_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [bls_pkg::PROD_W-1:0]  num,
   input  logic [bls_pkg::DEN_W-1:0]          den,
   output logic                               busy,
   output logic signed [bls_pkg::QUO_W-1:0]   quotient
);
   import bls_pkg::*;

   localparam int unsigned CNT_W = $clog2(QUO_W + 1);

   logic                busy_ff, busy_in;
   logic                neg_ff, neg_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic [PROD_W-1:0]   mag;
   logic [DEN_W:0]      trial;
   logic [DEN_W:0]      diff;
   logic                fits;

   always_comb begin
      mag   = num[PROD_W-1] ? (~num + 1'b1) : num;
      trial = {rem_ff, quo_ff[QUO_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});

      busy_in = busy_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;

      if (start) begin
         busy_in = 1'b1;
         neg_in  = num[PROD_W-1];
         den_in  = den;
         rem_in  = mag[PROD_W-1 -: DEN_W];
         quo_in  = mag[QUO_W-1:0];
         cnt_in  = CNT_W'(QUO_W);
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? $signed(~quo_ff + 1'b1) : $signed(quo_ff);

endmodule

/* src/bls_datapath.sv */
// Datapath: filter state, tau registers, shared multiplier, divider and result register.
module bls_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  bls_pkg::dp_cmd_type           cmd,
   output bls_pkg::dp_status_type        status,
   input  bls_pkg::req_item_type         req_item,
   input  logic                          csr_write,
   input  bls_pkg::csr_index_type        csr_index,
   input  logic [bls_pkg::TAU_W-1:0]     csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bls_pkg::rsp_item_type         rsp_item
);
   import bls_pkg::*;

   function automatic logic signed [COORD_W-1:0] halve_sat(
      input logic signed [CENTER_W-1:0] ctr,
      input logic [SIZE_W-1:0]          side
   );
      logic signed [CENTER_W:0]   diff;
      logic signed [CENTER_W-1:0] half;
      diff = {ctr[CENTER_W-1], ctr} - $signed({4'b0000, side});
      half = diff[CENTER_W:1];
      if (half > $signed(CENTER_W'(32767))) begin
         return 16'sh7fff;
      end else if (half < -$signed(CENTER_W'(32768))) begin
         return 16'sh8000;
      end else begin
         return half[COORD_W-1:0];
      end
   endfunction

   // configuration
   logic [TAU_W-1:0] scale_tau_ff, scale_tau_in;
   logic [TAU_W-1:0] center_tau_ff, center_tau_in;

   // captured item
   logic signed [COORD_W-1:0]  left_ff, top_ff;
   logic [SIZE_W-1:0]          width_ff, height_ff;
   logic [STAMP_W-1:0]         stamp_ff;
   logic signed [CENTER_W-1:0] cx_ff, cy_ff;
   logic signed [CENTER_W-1:0] cx_in, cy_in;

   // filter state
   logic                       primed_ff, primed_in;
   logic [STAMP_W-1:0]         last_stamp_ff, last_stamp_in;
   logic signed [CENTER_W-1:0] last_cx_ff, last_cx_in;
   logic signed [CENTER_W-1:0] last_cy_ff, last_cy_in;
   logic [SIDE_W-1:0]          last_side_ff, last_side_in;

   // per-item working registers
   logic                       gap_ff, gap_in;
   logic [T16_W-1:0]           t16_ff, t16_in;
   logic [STAMP_W-1:0]         elapsed;
   logic signed [PROD_W-1:0]   prod_ff, acc_ff, num_ff;
   logic signed [CENTER_W-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [SIDE_W-1:0]          ns_ff, ns_in;

   // result register
   logic                       out_valid_ff, out_valid_in;
   rsp_item_type               out_ff, out_in;

   logic [TAU_W-1:0]           tau_sel;
   logic [DEN_W-1:0]           den;
   logic signed [CENTER_W-1:0] cur_sel, prev_sel, new_val;
   logic signed [MUL_A_W-1:0]  mul_op_a;
   logic signed [CENTER_W-1:0] mul_op_b;
   logic signed [PROD_W-1:0]   product;
   logic                       div_busy;
   logic signed [QUO_W-1:0]    quotient;
   logic [SIZE_W-1:0]          side_sat;

   bls_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (num_ff),
      .den      (den),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      cx_in = $signed({req_item.box_left[COORD_W-1], req_item.box_left, 1'b0})
            + $signed({3'b000, req_item.box_width});
      cy_in = $signed({req_item.box_top[COORD_W-1], req_item.box_top, 1'b0})
            + $signed({3'b000, req_item.box_height});

      elapsed = stamp_ff - last_stamp_ff;
      gap_in  = (elapsed > GAP_LIMIT_MS);
      t16_in  = gap_in ? '0 : {elapsed[GAP_T_W-1:0], {SUB_SHIFT{1'b0}}};

      case (cmd.sel)
         CHAN_X: begin
            tau_sel  = center_tau_ff;
            cur_sel  = cx_ff;
            prev_sel = last_cx_ff;
         end
         CHAN_Y: begin
            tau_sel  = center_tau_ff;
            cur_sel  = cy_ff;
            prev_sel = last_cy_ff;
         end
         CHAN_SIDE: begin
            tau_sel  = scale_tau_ff;
            cur_sel  = $signed({3'b000, width_ff});
            prev_sel = $signed({2'b00, last_side_ff});
         end
         default: begin
            tau_sel  = scale_tau_ff;
            cur_sel  = $signed({3'b000, width_ff});
            prev_sel = $signed({2'b00, last_side_ff});
         end
      endcase

      den = DEN_W'(t16_ff) + DEN_W'(tau_sel);

      mul_op_a = cmd.mul_b ? $signed(MUL_A_W'(t16_ff)) : $signed(MUL_A_W'(tau_sel));
      mul_op_b = cmd.mul_b ? cur_sel : prev_sel;
      product  = mul_op_a * mul_op_b;

      new_val = cmd.take_cur ? cur_sel : quotient;

      nx_in = nx_ff;
      ny_in = ny_ff;
      ns_in = ns_ff;
      if (cmd.take_cur || cmd.write_quo) begin
         case (cmd.sel)
            CHAN_X:    nx_in = new_val;
            CHAN_Y:    ny_in = new_val;
            CHAN_SIDE: ns_in = new_val[SIDE_W-1:0];
            default:   ns_in = new_val[SIDE_W-1:0];
         endcase
      end

      side_sat = ns_ff[SIDE_W-1] ? {SIZE_W{1'b1}} : ns_ff[SIZE_W-1:0];

      scale_tau_in  = scale_tau_ff;
      center_tau_in = center_tau_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SCALE_TAU:  scale_tau_in  = csr_data;
            CSR_CENTER_TAU: center_tau_in = csr_data;
            default:        scale_tau_in  = scale_tau_ff;
         endcase
      end

      primed_in     = primed_ff;
      last_stamp_in = last_stamp_ff;
      last_cx_in    = last_cx_ff;
      last_cy_in    = last_cy_ff;
      last_side_in  = last_side_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;

      if (cmd.load_first) begin
         primed_in     = 1'b1;
         last_stamp_in = stamp_ff;
         last_cx_in    = cx_ff;
         last_cy_in    = cy_ff;
         last_side_in  = SIDE_W'(width_ff);
         out_in.smooth_left   = left_ff;
         out_in.smooth_top    = top_ff;
         out_in.smooth_width  = width_ff;
         out_in.smooth_height = height_ff;
         out_valid_in  = 1'b1;
      end else if (cmd.load_out) begin
         last_stamp_in = stamp_ff;
         last_cx_in    = nx_ff;
         last_cy_in    = ny_ff;
         last_side_in  = ns_ff;
         out_in.smooth_left   = halve_sat(nx_ff, side_sat);
         out_in.smooth_top    = halve_sat(ny_ff, side_sat);
         out_in.smooth_width  = side_sat;
         out_in.smooth_height = side_sat;
         out_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_tau_ff  <= SCALE_TAU_RESET;
         center_tau_ff <= CENTER_TAU_RESET;
         primed_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         scale_tau_ff  <= scale_tau_in;
         center_tau_ff <= center_tau_in;
         primed_ff     <= primed_in;
         out_valid_ff  <= out_valid_in;
      end

      if (cmd.capture) begin
         left_ff   <= req_item.box_left;
         top_ff    <= req_item.box_top;
         width_ff  <= req_item.box_width;
         height_ff <= req_item.box_height;
         stamp_ff  <= req_item.stamp_ms;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
      end
      if (cmd.prep) begin
         gap_ff <= gap_in;
         t16_ff <= t16_in;
      end
      if (cmd.mul_a || cmd.mul_b) begin
         prod_ff <= product;
      end
      if (cmd.mul_b) begin
         acc_ff <= prod_ff;
      end
      if (cmd.sum) begin
         num_ff <= acc_ff + prod_ff;
      end

      nx_ff         <= nx_in;
      ny_ff         <= ny_in;
      ns_ff         <= ns_in;
      last_stamp_ff <= last_stamp_in;
      last_cx_ff    <= last_cx_in;
      last_cy_ff    <= last_cy_in;
      last_side_ff  <= last_side_in;
      out_ff        <= out_in;
   end

   assign status.primed   = primed_ff;
   assign status.bypass   = gap_ff || (den == '0);
   assign status.div_busy = div_busy;
   assign status.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

/* src/bls_controller.sv */
// Controller: sequences capture, three blends (x, y, side) or a first-box pass-through, and the result transfer.
module bls_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bls_pkg::dp_status_type  status,
   output bls_pkg::dp_cmd_type     cmd
);
   import bls_pkg::*;

   ctl_state_type state_ff, state_in;
   chan_type      sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= CHAN_X;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.sel   = sel_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            sel_in   = CHAN_X;
            state_in = status.primed ? ST_MUL_A : ST_FIRST;
         end
         ST_FIRST: begin
            if (status.out_free) begin
               cmd.load_first = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_MUL_A: begin
            if (status.bypass) begin
               cmd.take_cur = 1'b1;
               if (sel_ff == CHAN_SIDE) begin
                  state_in = ST_FINISH;
               end else begin
                  sel_in = (sel_ff == CHAN_X) ? CHAN_Y : CHAN_SIDE;
               end
            end else begin
               cmd.mul_a = 1'b1;
               state_in  = ST_MUL_B;
            end
         end
         ST_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               cmd.write_quo = 1'b1;
               if (sel_ff == CHAN_SIDE) begin
                  state_in = ST_FINISH;
               end else begin
                  sel_in   = (sel_ff == CHAN_X) ? CHAN_Y : CHAN_SIDE;
                  state_in = ST_MUL_A;
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/box_lowpass_smoother_unit.sv */
// Top level: bounding-box low-pass smoother with variable time step, one box at a time.
// Centre x, centre y and side each run two multiplies, a sum and an 18-step restoring divide.
// A bypassed one takes the current value; no new box is taken until the result is loaded.
// Gap over 200 ms or zero divisor bypasses the multiply and the divide.
// The first box after reset passes through. A result still held stalls only the final step.
// Synchronous active-high reset clears the filter and restores the default time constants.
module box_lowpass_smoother_unit (
   input logic       clock,
   input logic       reset,
   bls_req_if.sink   req_bus,
   bls_rsp_if.source rsp_bus,
   bls_csr_if.sink   csr_bus
);
   import bls_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   req_item_type  req_item;
   rsp_item_type  rsp_item;
   logic          req_ready;
   logic          rsp_valid;

   assign req_item.box_left   = req_bus.box_left;
   assign req_item.box_top    = req_bus.box_top;
   assign req_item.box_width  = req_bus.box_width;
   assign req_item.box_height = req_bus.box_height;
   assign req_item.stamp_ms   = req_bus.stamp_ms;
   assign req_bus.ready       = req_ready;

   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid         = rsp_valid;
   assign rsp_bus.smooth_left   = rsp_item.smooth_left;
   assign rsp_bus.smooth_top    = rsp_item.smooth_top;
   assign rsp_bus.smooth_width  = rsp_item.smooth_width;
   assign rsp_bus.smooth_height = rsp_item.smooth_height;

   bls_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bls_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .csr_write (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_item  (rsp_item)
   );

endmodule

/* test/tb_top.sv */
// Testbench for the box smoother: random-paced box stream checked against a filter predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bls_pkg::*;

   localparam int QUIET_LIMIT = 3000;

   logic clock;
   logic reset;

   bls_req_if req_bus();
   bls_rsp_if rsp_bus();
   bls_csr_if csr_bus();

   box_lowpass_smoother_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // filter state as the block should hold it
   logic [TAU_W-1:0]           scale_tau;
   logic [TAU_W-1:0]           center_tau;
   bit                         primed;
   logic [STAMP_W-1:0]         last_stamp;
   logic signed [CENTER_W-1:0] last_cx;
   logic signed [CENTER_W-1:0] last_cy;
   logic [SIDE_W-1:0]          last_side;

   req_item_type pending_boxes[$];
   rsp_item_type expected_boxes[$];
   req_item_type sent_box;

   int          boxes_queued;
   int          results_seen;
   int          errors;
   int          quiet_cycles;
   int unsigned send_wait;
   int unsigned stall_left;
   bit          calm_send;
   bit          calm_recv;

   logic [STAMP_W-1:0] clock_ms;
   longint             trk_left, trk_top, trk_w, trk_h;

   function automatic longint clamp_to(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint blend(longint prev, longint cur, longint tau, longint t16,
                                    bit gap);
      longint den;
      den = t16 + tau;
      if (gap || den == 0)
         return cur;
      return (tau * prev + t16 * cur) / den;
   endfunction

   function automatic rsp_item_type smooth_box(req_item_type b);
      rsp_item_type       r;
      longint             cx, cy, w, t16, nx, ny, ns, side;
      logic [STAMP_W-1:0] dt;
      bit                 gap;
      w  = longint'(b.box_width);
      cx = 2 * longint'($signed(b.box_left)) + w;
      cy = 2 * longint'($signed(b.box_top)) + longint'(b.box_height);
      if (!primed) begin
         primed     = 1'b1;
         last_stamp = b.stamp_ms;
         last_cx    = cx[CENTER_W-1:0];
         last_cy    = cy[CENTER_W-1:0];
         last_side  = w[SIDE_W-1:0];
         r.smooth_left   = b.box_left;
         r.smooth_top    = b.box_top;
         r.smooth_width  = b.box_width;
         r.smooth_height = b.box_height;
         return r;
      end
      dt  = b.stamp_ms - last_stamp;
      gap = dt > GAP_LIMIT_MS;
      t16 = gap ? 0 : longint'(dt) * 16;
      nx  = blend(longint'(last_cx), cx, longint'(center_tau), t16, gap);
      ny  = blend(longint'(last_cy), cy, longint'(center_tau), t16, gap);
      ns  = blend(longint'(last_side), w, longint'(scale_tau), t16, gap);
      side = clamp_to(ns, 0, 32767);
      r.smooth_left   = COORD_W'(clamp_to((nx - side) >>> 1, -32768, 32767));
      r.smooth_top    = COORD_W'(clamp_to((ny - side) >>> 1, -32768, 32767));
      r.smooth_width  = SIZE_W'(side);
      r.smooth_height = SIZE_W'(side);
      last_stamp = b.stamp_ms;
      last_cx    = nx[CENTER_W-1:0];
      last_cy    = ny[CENTER_W-1:0];
      last_side  = ns[SIDE_W-1:0];
      return r;
   endfunction

   task automatic check_field(string what, longint want_v, longint got_v);
      if (want_v != got_v) begin
         errors++;
         $display("%0t: %s expected %0d, actual %0d", $time, what, want_v, got_v);
      end
   endtask

   task automatic add_box(longint l, longint t, longint w, longint h, logic [STAMP_W-1:0] dt);
      req_item_type b;
      clock_ms     = clock_ms + dt;
      b.box_left   = l[COORD_W-1:0];
      b.box_top    = t[COORD_W-1:0];
      b.box_width  = w[SIZE_W-1:0];
      b.box_height = h[SIZE_W-1:0];
      b.stamp_ms   = clock_ms;
      pending_boxes = {pending_boxes, b};
      boxes_queued++;
   endtask

   // mostly a box drifting on a track at frame-like intervals, some jumps and odd timing
   task automatic add_random_boxes(int count);
      int unsigned        pick;
      logic [STAMP_W-1:0] dt;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)
            dt = $urandom_range(0, 200);
         else if (pick < 68)
            dt = 0;
         else if (pick < 76)
            dt = $urandom_range(195, 205);
         else if (pick < 92)
            dt = $urandom_range(201, 5000);
         else
            dt = $urandom();
         if ($urandom_range(0, 3) != 0) begin
            trk_left = clamp_to(trk_left + int'($urandom_range(0, 128)) - 64, -32768, 32767);
            trk_top  = clamp_to(trk_top + int'($urandom_range(0, 128)) - 64, -32768, 32767);
            trk_w    = clamp_to(trk_w + int'($urandom_range(0, 64)) - 32, 0, 32767);
            trk_h    = clamp_to(trk_h + int'($urandom_range(0, 64)) - 32, 0, 32767);
         end else begin
            trk_left = longint'(int'($urandom_range(0, 65535)) - 32768);
            trk_top  = longint'(int'($urandom_range(0, 65535)) - 32768);
            trk_w    = longint'($urandom_range(0, 32767));
            trk_h    = longint'($urandom_range(0, 32767));
         end
         add_box(trk_left, trk_top, trk_w, trk_h, dt);
      end
   endtask

   task automatic settle();
      while (results_seen < boxes_queued)
         @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [TAU_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do
         @(posedge clock);
      while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_SCALE_TAU)
         scale_tau = value;
      else
         center_tau = value;
   endtask

   task automatic set_taus(logic [TAU_W-1:0] scale_v, logic [TAU_W-1:0] center_v);
      settle();
      write_reg(CSR_SCALE_TAU, scale_v);
      write_reg(CSR_CENTER_TAU, center_v);
   endtask

   function automatic logic [TAU_W-1:0] random_tau();
      return ($urandom_range(0, 3) == 0) ? TAU_W'($urandom_range(0, 64))
                                         : TAU_W'($urandom_range(0, 65535));
   endfunction

   // box source
   always @(posedge clock) begin : drive_req
      bit taken;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_wait = 0;
      end else begin
         taken = req_bus.valid && req_bus.ready;
         if (taken)
            expected_boxes = {expected_boxes, smooth_box(sent_box)};
         if (taken || !req_bus.valid) begin
            if (send_wait != 0) begin
               send_wait--;
               req_bus.valid <= 1'b0;
            end else if (pending_boxes.size() != 0) begin
               sent_box = pending_boxes.pop_front();
               req_bus.box_left   <= sent_box.box_left;
               req_bus.box_top    <= sent_box.box_top;
               req_bus.box_width  <= sent_box.box_width;
               req_bus.box_height <= sent_box.box_height;
               req_bus.stamp_ms   <= sent_box.stamp_ms;
               req_bus.valid      <= 1'b1;
               if ($urandom_range(0, 63) == 0)
                  calm_send = !calm_send;
               send_wait = calm_send ? 0 : $urandom_range(0, 15);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result sink and checker
   always @(posedge clock) begin : watch_rsp
      rsp_item_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_boxes.size() == 0) begin
               errors++;
               $display("%0t: unexpected result left %0d top %0d width %0d height %0d",
                        $time, rsp_bus.smooth_left, rsp_bus.smooth_top,
                        rsp_bus.smooth_width, rsp_bus.smooth_height);
            end else begin
               want = expected_boxes.pop_front();
               check_field("smooth_left", want.smooth_left, rsp_bus.smooth_left);
               check_field("smooth_top", want.smooth_top, rsp_bus.smooth_top);
               check_field("smooth_width", want.smooth_width, rsp_bus.smooth_width);
               check_field("smooth_height", want.smooth_height, rsp_bus.smooth_height);
            end
            if ($urandom_range(0, 63) == 0)
               calm_recv = !calm_recv;
            stall_left = calm_recv ? 0 : $urandom_range(0, 15);
         end else if (rsp_bus.valid && stall_left != 0) begin
            stall_left--;
         end
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.box_left   = '0;
      req_bus.box_top    = '0;
      req_bus.box_width  = '0;
      req_bus.box_height = '0;
      req_bus.stamp_ms   = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_SCALE_TAU;
      csr_bus.data       = '0;
      scale_tau    = SCALE_TAU_RESET;
      center_tau   = CENTER_TAU_RESET;
      primed       = 1'b0;
      boxes_queued = 0;
      results_seen = 0;
      errors       = 0;
      quiet_cycles = 0;
      calm_send    = 1'b0;
      calm_recv    = 1'b0;
      clock_ms     = 32'hFFFF_FF38;
      trk_left = 0;
      trk_top  = 0;
      trk_w    = 800;
      trk_h    = 600;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // default time constants; first box passes through, then stamp wraps past zero
      add_box(-32768, 32767, 32767, 0, 0);
      add_box(-32768, -32768, 0, 32767, 0);
      add_box(-32768, 32767, 0, 32767, 1);
      add_box(32767, 32767, 0, 32767, 201);
      add_box(0, 0, 100, 100, 200);
      add_box(1, -1, 21845, 10922, 150);
      add_box(-1, 1, 10922, 21845, 32'h8000_0000);
      add_box(12345, -12345, 32767, 32767, 200);
      add_random_boxes(300);

      // zero divisor when no time passes
      set_taus(16'd0, 16'd0);
      add_box(-20000, 20000, 5000, 300, 0);
      add_box(20000, -20000, 300, 5000, 0);
      add_box(100, 200, 3000, 4000, 3);
      add_random_boxes(150);

      set_taus(16'hFFFF, 16'hFFFF);
      add_box(-32768, -32768, 32767, 32767, 1);
      add_box(32767, 32767, 0, 0, 200);
      add_box(0, 0, 16384, 16384, 0);
      add_random_boxes(250);

      set_taus(16'd0, 16'hFFFF);
      add_random_boxes(150);
      set_taus(16'hFFFF, 16'd0);
      add_random_boxes(150);

      repeat (4) begin
         set_taus(random_tau(), random_tau());
         add_random_boxes(175);
      end

      settle();
      repeat (100) @(posedge clock);
      if (expected_boxes.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $time, expected_boxes.size());
      end
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
